[rtl/ntv_pkg.sv]
// ntv_pkg: beat types, parse phases, character codes and defaults for the
// nested tag validator. No dependencies.
package ntv_pkg;

    localparam int STACK_DEPTH_DEF  = 64;
    localparam int MAX_NAME_LEN_DEF = 9;
    localparam int LEN_W            = 4;   // holds a name length up to 15
    localparam int LETTER_W         = 5;   // letter code, A = 0
    localparam int PREFIX_LEN       = 7;   // "[CDATA[" after "<!"

    localparam logic [7:0] CH_LT    = 8'h3C; // '<'
    localparam logic [7:0] CH_GT    = 8'h3E; // '>'
    localparam logic [7:0] CH_SLASH = 8'h2F; // '/'
    localparam logic [7:0] CH_BANG  = 8'h21; // '!'
    localparam logic [7:0] CH_A     = 8'h41; // 'A'
    localparam logic [7:0] CH_Z     = 8'h5A; // 'Z'
    localparam logic [7:0] CH_RBR   = 8'h5D; // ']'
    localparam logic [7:0] CH_LBR   = 8'h5B; // '['

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic valid_res;
        logic overflow;
    } t_out_beat;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

    typedef enum logic [7:0] {
        PH_START        = 8'b0000_0001,
        PH_CONTENT      = 8'b0000_0010,
        PH_LT           = 8'b0000_0100,
        PH_START_NAME   = 8'b0000_1000,
        PH_END_NAME     = 8'b0001_0000,
        PH_CDATA_PREFIX = 8'b0010_0000,
        PH_CDATA_BODY   = 8'b0100_0000,
        PH_DONE         = 8'b1000_0000
    } t_phase;

    // Expected character of the CDATA prefix after "<!", by position.
    function automatic logic [7:0] cdata_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = CH_LBR;
            3'd1:    c = 8'h43; // 'C'
            3'd2:    c = 8'h44; // 'D'
            3'd3:    c = 8'h41; // 'A'
            3'd4:    c = 8'h54; // 'T'
            3'd5:    c = 8'h41; // 'A'
            3'd6:    c = CH_LBR;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[rtl/ntv_cell.sv]
// ntv_cell: one slot of the shifting name stack.
// Depends on ntv_pkg (stack control struct).
module ntv_cell #(
    parameter int W = 49
) (
    input  logic               i_clk,
    input  ntv_pkg::t_stack_ctl i_ctl,
    input  logic [W-1:0]       i_from_above,
    input  logic [W-1:0]       i_from_below,
    output logic [W-1:0]       o_entry
);
    import ntv_pkg::*;

    logic [W-1:0] r_entry;
    logic [W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            n_entry = i_from_above;
        end else if (i_ctl.pop) begin
            n_entry = i_from_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

[rtl/ntv_stack.sv]
// ntv_stack: row of ntv_cell slots; top of stack always sits in slot 0.
// Depends on ntv_pkg and ntv_cell.
module ntv_stack #(
    parameter int DEPTH = 64,
    parameter int W     = 49
) (
    input  logic               i_clk,
    input  ntv_pkg::t_stack_ctl i_ctl,
    input  logic [W-1:0]       i_push_entry,
    output logic [W-1:0]       o_top
);
    import ntv_pkg::*;

    logic [W-1:0] entries [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [W-1:0] above;
        logic [W-1:0] below;
        if (g == 0) begin : g_head
            assign above = i_push_entry;
        end else begin : g_body
            assign above = entries[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign below = '0;  // slot below the bottom is never read
        end else begin : g_mid
            assign below = entries[g+1];
        end
        ntv_cell #(.W(W)) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_from_above (above),
            .i_from_below (below),
            .o_entry      (entries[g])
        );
    end

    assign o_top = entries[0];

endmodule

[rtl/nested_tag_validator.sv]
// nested_tag_validator: one character per beat, one verdict per snippet.
// Verdict goes to the output register, or the skid slot if output is stalled.
// Throughput: one character per cycle; the shifting name stack never stalls.
// Input stalls only while a second verdict waits behind a stalled output beat.
// Reset: synchronous active-low i_rst_n clears parser and output state;
// stack cells have no reset and are pushed before read. Needs ntv_stack.
module nested_tag_validator #(
    parameter int STACK_DEPTH  = ntv_pkg::STACK_DEPTH_DEF,
    parameter int MAX_NAME_LEN = ntv_pkg::MAX_NAME_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ntv_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ntv_pkg::t_out_beat o_out
);
    import ntv_pkg::*;

    localparam int BUF_W   = LETTER_W * MAX_NAME_LEN;
    localparam int ENTRY_W = LEN_W + BUF_W;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    t_phase              r_phase,  n_phase;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [LEN_W-1:0]    r_len,    n_len;
    logic [BUF_W-1:0]    r_buf,    n_buf;
    logic                r_mis,    n_mis;
    logic [2:0]          r_pp,     n_pp;
    logic [1:0]          r_br,     n_br;
    logic                r_failed, n_failed;
    logic                r_ovf,    n_ovf;

    // Output register plus one skid slot
    logic      r_out_valid;
    t_out_beat r_out;
    logic      r_skid_valid;
    t_out_beat r_skid;

    logic                in_acc;
    logic                out_take;
    logic [7:0]          c;
    logic                c_upper;
    logic [LETTER_W-1:0] letter;
    logic                len_room;
    t_stack_ctl          stk_ctl;
    logic [ENTRY_W-1:0]  top;
    logic [LEN_W-1:0]    top_len;
    logic [LETTER_W-1:0] top_letter;
    t_out_beat           res;

    // Input is held off only while the skid slot is occupied.
    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    assign c        = i_in.ch;
    assign c_upper  = (c >= CH_A) && (c <= CH_Z);
    assign letter   = LETTER_W'(c - CH_A);
    assign len_room = r_len < LEN_W'(MAX_NAME_LEN);

    // ---------------------------------------------------------------
    // Name stack: top entry is {length, letters}
    // ---------------------------------------------------------------
    ntv_stack #(
        .DEPTH (STACK_DEPTH),
        .W     (ENTRY_W)
    ) u_stack (
        .i_clk        (i_clk),
        .i_ctl        (stk_ctl),
        .i_push_entry ({r_len, r_buf}),
        .o_top        (top)
    );

    assign top_len = top[BUF_W +: LEN_W];

    // letter of the top name at the position being compared
    always_comb begin
        top_letter = '0;
        for (int k = 0; k < MAX_NAME_LEN; k++) begin
            if (LEN_W'(k) == r_len) begin
                top_letter = top[LETTER_W*k +: LETTER_W];
            end
        end
    end

    // ---------------------------------------------------------------
    // Per-character parse step
    // ---------------------------------------------------------------
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_len    = r_len;
        n_buf    = r_buf;
        n_mis    = r_mis;
        n_pp     = r_pp;
        n_br     = r_br;
        n_failed = r_failed;
        n_ovf    = r_ovf;
        stk_ctl  = '0;
        if (in_acc && !r_failed) begin
            unique case (r_phase)
                PH_START: begin
                    if (c == CH_LT) n_phase = PH_LT;
                    else            n_failed = 1'b1;
                end
                PH_CONTENT: begin
                    if (c == CH_LT) n_phase = PH_LT;
                end
                PH_LT: begin
                    if (c == CH_SLASH && r_count != '0) begin
                        n_phase = PH_END_NAME;
                        n_len   = '0;
                        n_mis   = 1'b0;
                    end else if (c == CH_BANG && r_count != '0) begin
                        n_phase = PH_CDATA_PREFIX;
                        n_pp    = '0;
                    end else if (c_upper) begin
                        n_phase = PH_START_NAME;
                        n_buf   = BUF_W'(letter);
                        n_len   = LEN_W'(1);
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_START_NAME: begin
                    if (c_upper && len_room) begin
                        for (int k = 0; k < MAX_NAME_LEN; k++) begin
                            if (LEN_W'(k) == r_len) begin
                                n_buf[LETTER_W*k +: LETTER_W] = letter;
                            end
                        end
                        n_len = r_len + LEN_W'(1);
                    end else if (c == CH_GT) begin
                        if (r_count >= CNT_W'(STACK_DEPTH)) begin
                            n_failed = 1'b1;
                            n_ovf    = 1'b1;
                        end else begin
                            stk_ctl.push = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                            n_phase      = PH_CONTENT;
                        end
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_END_NAME: begin
                    if (c_upper && len_room) begin
                        if (r_len >= top_len || top_letter != letter) n_mis = 1'b1;
                        n_len = r_len + LEN_W'(1);
                    end else if (c == CH_GT) begin
                        if (r_len == '0 || r_len != top_len || r_mis) begin
                            n_failed = 1'b1;
                        end else begin
                            stk_ctl.pop = 1'b1;
                            n_count     = r_count - CNT_W'(1);
                            n_phase     = (n_count == '0) ? PH_DONE : PH_CONTENT;
                        end
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_CDATA_PREFIX: begin
                    if (r_pp < 3'(PREFIX_LEN) && c == cdata_char(r_pp)) begin
                        n_pp = r_pp + 3'd1;
                        if (n_pp == 3'(PREFIX_LEN)) begin
                            n_phase = PH_CDATA_BODY;
                            n_br    = '0;
                        end
                    end else begin
                        n_failed = 1'b1;
                    end
                end
                PH_CDATA_BODY: begin
                    if (c == CH_RBR) begin
                        if (r_br < 2'd2) n_br = r_br + 2'd1;
                    end else if (c == CH_GT && r_br == 2'd2) begin
                        n_phase = PH_CONTENT;
                        n_br    = '0;
                    end else begin
                        n_br = '0;
                    end
                end
                PH_DONE: begin
                    n_failed = 1'b1;  // trailing text after the outer tag
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase
        end
    end

    // verdict reflects the state after this character
    assign res.valid_res = !n_failed && (n_phase == PH_DONE);
    assign res.overflow  = n_ovf;

    // state returns to reset after the last character of a snippet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_in.last)) begin
            r_phase  <= PH_START;
            r_count  <= '0;
            r_len    <= '0;
            r_buf    <= '0;
            r_mis    <= 1'b0;
            r_pp     <= '0;
            r_br     <= '0;
            r_failed <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_len    <= n_len;
            r_buf    <= n_buf;
            r_mis    <= n_mis;
            r_pp     <= n_pp;
            r_br     <= n_br;
            r_failed <= n_failed;
            r_ovf    <= n_ovf;
        end
    end

    // ---------------------------------------------------------------
    // Output beat buffering
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc && i_in.last) begin
            if (!r_out_valid || out_take) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot filled while output register empty");

    a_ovf_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.overflow && o_out.valid_res))
        else $error("overflowed snippet reported valid");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.last) |=> (r_phase == PH_START && r_count == '0 && !r_failed))
        else $error("parser not back at start after last beat");

endmodule
